// ----- src/frms_pkg.sv -----
package frms_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int ENERGY_W  = 16;
    localparam int FLEN_W    = 12;
    localparam int TDATA_W   = 48;

    // Default parameter values
    localparam int DEF_HOP_LEN     = 512;
    localparam int DEF_SAMPLE_BITS = 16;

    // A frame is built from this many hop blocks
    localparam int BLOCKS_PER_FRAME = 4;
    localparam logic [1:0] BLOCKS_HELD_MAX = 2'd3;

    // Arithmetic widths
    localparam int SUM_W    = 40;           // one block sum of squares
    localparam int PAIR_W   = SUM_W + 1;    // two newest held blocks
    localparam int TOTAL_W  = SUM_W + 2;    // up to four block sums
    localparam int ROOT_W   = TOTAL_W / 2;  // square root of a TOTAL_W value
    localparam int LEN_W    = 14;           // frame lengths up to 16383
    localparam int Q_DEPTH  = 2;

    // Frame request passed from the front to the back
    typedef struct packed {
        logic               last;
        logic [LEN_W-1:0]   len;
        logic [SUM_W-1:0]   acc;
        logic [TOTAL_W-1:0] held;
    } job_t;

    // Back-end sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

endpackage

// ----- src/framed_rms_energy_onset_top.sv -----
// Overlapped-frame RMS energy and onset envelope.
// Input stream (s_*): one signed Q15 audio sample per request; s_tlast marks
// the stream's final sample. Output stream (m_*): one request per completed
// frame (every HOP_LEN samples once three hop blocks are held) and one more
// partial frame on the final sample when no full frame ends there.
// The front squares and accumulates one sample per cycle while s_tready is
// high, and tracks hop blocks; frame requests pass through a two-entry
// queue to the back, which runs a bit-serial divider, then a bit-serial
// square root. A frame's request is pushed from the square register into
// the queue; the back divides, takes the root and loads the output register,
// raising m_tvalid. It starts a frame only after loading the last result,
// and s_tready drops only while a frame request waits on a full queue.
// Reset (aresetn low, synchronous) clears the block sums, counters, queue,
// previous energy and output valid. After the final sample all tracking state
// returns to its reset value. When m_tready stays low the result holds in the
// output register; the back finishes the next frame meanwhile, then the queue
// fills and finally s_tready drops.
module framed_rms_energy_onset_top
    import frms_pkg::*;
#(
    parameter int HOP_LEN     = DEF_HOP_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata    // [15:0] energy, [31:16] onset,
                                           // [43:32] frame_length, [47:44] zero
);

    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Accept samples, accumulate squares, issue frame requests
    frms_front #(
        .HOP_LEN     (HOP_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    // Decouple sample intake from the slow divide and root
    frms_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_job),
        .pop     (pop),
        .dout    (head_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Divide, take the root, form onset, hold the result
    frms_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .job      (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- src/frms_front.sv -----
module frms_front
    import frms_pkg::*;
#(
    parameter int HOP_LEN     = DEF_HOP_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output job_t                job
);

    localparam int EXT_W  = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int FILL_W = $clog2(HOP_LEN + 1);

    logic [EXT_W-1:0]       sample_ext;
    logic [SAMPLE_BITS-1:0] sample_raw;
    logic signed [SQ_W-1:0] square;

    logic                   v1_reg;
    logic [SUM_W-1:0]       sq_reg;
    logic                   last_reg;

    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       acc_next;
    logic [SUM_W-1:0]       s0_reg;
    logic [PAIR_W-1:0]      pair_reg;
    logic [TOTAL_W-1:0]     held_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic [1:0]             seen_reg;
    logic                   complete;
    logic                   emit;
    logic                   adv;

    // Sign-extend the low SAMPLE_BITS bits and square
    assign sample_ext = EXT_W'(s_tdata);
    assign sample_raw = sample_ext[SAMPLE_BITS-1:0];
    assign square     = $signed(sample_raw) * $signed(sample_raw);

    assign acc_next  = acc_reg + sq_reg;
    assign fill_next = fill_reg + FILL_W'(1);
    assign complete  = (fill_next >= FILL_W'(HOP_LEN));
    assign emit      = (complete && (seen_reg == BLOCKS_HELD_MAX)) || last_reg;
    assign adv       = v1_reg && !(emit && q_full);
    assign s_tready  = !v1_reg || adv;
    assign push      = v1_reg && emit && !q_full;

    assign job.last = last_reg;
    assign job.len  = LEN_W'(seen_reg) * LEN_W'(HOP_LEN) + LEN_W'(fill_next);
    assign job.acc  = acc_next;
    assign job.held = held_reg;

    // Square stage payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sq_reg   <= SUM_W'($unsigned(square));
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    // Block bookkeeping: accumulate, rotate on hop boundary, clear on stream end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            s0_reg   <= '0;
            pair_reg <= '0;
            held_reg <= '0;
            fill_reg <= '0;
            seen_reg <= '0;
        end else if (adv) begin
            if (last_reg) begin
                acc_reg  <= '0;
                s0_reg   <= '0;
                pair_reg <= '0;
                held_reg <= '0;
                fill_reg <= '0;
                seen_reg <= '0;
            end else if (complete) begin
                acc_reg  <= '0;
                fill_reg <= '0;
                s0_reg   <= acc_next;
                pair_reg <= PAIR_W'(s0_reg) + PAIR_W'(acc_next);
                held_reg <= TOTAL_W'(pair_reg) + TOTAL_W'(acc_next);
                if (seen_reg != BLOCKS_HELD_MAX) begin
                    seen_reg <= seen_reg + 2'd1;
                end
            end else begin
                acc_reg  <= acc_next;
                fill_reg <= fill_next;
            end
        end
    end

endmodule

// ----- src/frms_queue.sv -----
module frms_queue
    import frms_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output job_t dout,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    job_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/frms_back.sv -----
module frms_back
    import frms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  job_t               job,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int CNT_W  = $clog2(TOTAL_W);
    localparam int SREM_W = ROOT_W + 2;

    logic [1:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TOTAL_W-1:0]  work_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                last_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [ENERGY_W-1:0] prev_reg;
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg;

    logic [LEN_W:0]      rem_ext;
    logic                div_ge;
    logic [SREM_W+1:0]   srem_ext;
    logic [SREM_W+1:0]   trial;
    logic                sq_ge;
    logic [ENERGY_W-1:0] energy;
    logic [ENERGY_W-1:0] onset;
    logic                load_out;

    // One quotient bit per cycle
    assign rem_ext = {rem_reg, work_reg[TOTAL_W-1]};
    assign div_ge  = (rem_ext >= {1'b0, len_reg});

    // One root bit per cycle, two radicand bits consumed
    assign srem_ext = {srem_reg, work_reg[TOTAL_W-1 -: 2]};
    assign trial    = (SREM_W + 2)'({root_reg, 2'b01});
    assign sq_ge    = (srem_ext >= trial);

    assign energy = (|root_reg[ROOT_W-1:ENERGY_W]) ? {ENERGY_W{1'b1}}
                                                   : root_reg[ENERGY_W-1:0];
    assign onset  = (energy > prev_reg) ? energy - prev_reg : '0;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                work_reg <= job.held + TOTAL_W'(job.acc);
                len_reg  <= job.len;
                last_reg <= job.last;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(TOTAL_W - 1);
            end
            ST_DIV: begin
                rem_reg  <= div_ge ? LEN_W'(rem_ext - {1'b0, len_reg}) : LEN_W'(rem_ext);
                work_reg <= {work_reg[TOTAL_W-2:0], div_ge};
                if (cnt_reg == '0) begin
                    cnt_reg  <= CNT_W'(ROOT_W - 1);
                    root_reg <= '0;
                    srem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
            ST_SQRT: begin
                srem_reg <= sq_ge ? SREM_W'(srem_ext - trial) : SREM_W'(srem_ext);
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                work_reg <= {work_reg[TOTAL_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
        if (load_out) begin
            out_data_reg <= TDATA_W'({len_reg[FLEN_W-1:0], onset, energy});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (load_out) begin
                out_valid_reg <= 1'b1;
                prev_reg      <= last_reg ? '0 : energy;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/frms_frame_checker.sv -----
module frms_frame_checker
    import frms_pkg::*;
#(
    parameter int HOP_LEN     = DEF_HOP_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata,
    output int                  frames_due,
    output int                  mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN = BLOCKS_PER_FRAME * HOP_LEN;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] onset;
        logic [FLEN_W-1:0]   flen;
    } frame_t;

    frame_t              expected_frames[$];
    logic [SUM_W-1:0]    held_sums[3];
    logic [SUM_W-1:0]    open_sum;
    int                  open_fill;
    int                  held_count;
    logic [ENERGY_W-1:0] last_energy;

    // Bitwise floor square root, most significant bit first
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic clear_tracking();
        held_sums[0] = '0;
        held_sums[1] = '0;
        held_sums[2] = '0;
        open_sum     = '0;
        open_fill    = 0;
        held_count   = 0;
        last_energy  = '0;
    endtask

    task automatic queue_frame(input logic [63:0] sum, input int len);
        logic [63:0] root;
        frame_t      f;
        root     = floor_sqrt(sum / 64'(len));
        f.energy = (root > 64'hFFFF) ? 16'hFFFF : root[ENERGY_W-1:0];
        f.onset  = (f.energy > last_energy) ? f.energy - last_energy : '0;
        f.flen   = len[FLEN_W-1:0];
        last_energy = f.energy;
        expected_frames.insert(expected_frames.size(), f);
    endtask

    task automatic take_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
        logic signed [SAMPLE_BITS-1:0] narrow;
        longint                        value;
        longint                        square;
        logic [63:0]                   total;
        logic                          hop_done;
        narrow    = raw[SAMPLE_BITS-1:0];
        value     = narrow;
        square    = value * value;
        open_sum  = open_sum + square[SUM_W-1:0];
        open_fill = open_fill + 1;
        hop_done  = (open_fill >= HOP_LEN);
        total = 64'(held_sums[0]) + 64'(held_sums[1]) + 64'(held_sums[2]) + 64'(open_sum);

        // full frame wins over the partial one on the final sample
        if (hop_done && held_count >= 3)
            queue_frame(total, FRAME_LEN);
        else if (is_last)
            queue_frame(total, held_count * HOP_LEN + open_fill);

        if (is_last) begin
            clear_tracking();
        end else if (hop_done) begin
            held_sums[2] = held_sums[1];
            held_sums[1] = held_sums[0];
            held_sums[0] = open_sum;
            open_sum     = '0;
            open_fill    = 0;
            if (held_count < 3)
                held_count = held_count + 1;
        end
    endtask

    initial begin
        clear_tracking();
    end

    always @(posedge aclk) begin : watch
        frame_t got;
        frame_t want;
        int     bad;
        bad = 0;
        got = m_tdata[ENERGY_W*2+FLEN_W-1:0];
        if (!aresetn) begin
            clear_tracking();
            expected_frames.delete();
        end else begin
            // compare before predicting, so a new request never masks a stray result
            if (m_tvalid && m_tready) begin
                got.energy = m_tdata[15:0];
                got.onset  = m_tdata[31:16];
                got.flen   = m_tdata[43:32];
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: energy %0d onset %0d frame_length %0d",
                           got.energy, got.onset, got.flen);
                    bad++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.energy !== want.energy) begin
                        $error("energy: expected %0d, actual %0d", want.energy, got.energy);
                        bad++;
                    end
                    if (got.onset !== want.onset) begin
                        $error("onset: expected %0d, actual %0d", want.onset, got.onset);
                        bad++;
                    end
                    if (got.flen !== want.flen) begin
                        $error("frame_length: expected %0d, actual %0d", want.flen, got.flen);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tlast);
        end
        mismatches <= mismatches + bad;
        frames_due <= expected_frames.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench
    import frms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOP       = DEF_HOP_LEN;
    localparam int LIMIT     = 1_000_000;
    localparam int MIN_ITEMS = 1100;
    localparam int MIN_RUNS  = 8;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;      // [15:0] sample
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;      // [15:0] energy, [31:16] onset,
                                       // [43:32] frame_length, [47:44] zero
    int                  frames_due;
    int                  mismatches;
    int                  cycle_count;
    int                  items_sent;
    int                  streams_done;
    bit                  calm;         // set for the closing stretch: no idling at all

    framed_rms_energy_onset_top #(
        .HOP_LEN     (HOP),
        .SAMPLE_BITS (DEF_SAMPLE_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Watch both channels, predict every frame and compare it field by field
    frms_frame_checker #(
        .HOP_LEN     (HOP),
        .SAMPLE_BITS (DEF_SAMPLE_BITS)
    ) frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .frames_due (frames_due),
        .mismatches (mismatches)
    );

    // 12 ns clock, starting high
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Watchdog: end the run if the block hangs or a frame never shows up
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall m_tready in random bursts, with quiet
    // stretches between them; hold it high for good once calm is set.
    initial begin : rx_stalls
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!calm && aresetn) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(negedge aclk);
                        m_tready <= 1'b1;
                    end
                    2: begin
                        repeat ($urandom_range(50, 300)) @(negedge aclk);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Pick one sample at a loudness level: 0..15 scales a random word down,
    // anything above picks one of the extreme codes.
    function automatic logic [SAMPLE_W-1:0] make_sample(input int level);
        logic [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        if (level > 15) begin
            case ($urandom_range(0, 4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return $signed(r) >>> (15 - level);
    endfunction

    // Offer one sample request at the falling edge and hold it until taken.
    // A gappy sender may first drop valid for a random burst.
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input bit gappy);
        @(negedge aclk);
        if (gappy && !calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid at the next falling edge
    task automatic hold_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Send one whole stream of len samples, the last one flagged. Loudness
    // changes per hop block so frame energy rises and falls and onsets vary.
    task automatic run_stream(input int len, input bit gappy);
        int level;
        level = 0;
        for (int i = 0; i < len; i++) begin
            if (i % HOP == 0)
                level = $urandom_range(0, 16);
            push_sample(make_sample(level), i == len - 1, gappy);
        end
        streams_done++;
    endtask

    initial begin : stimulus
        int len;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        aresetn      = 1'b0;
        calm         = 1'b0;
        items_sent   = 0;
        streams_done = 0;
        len          = 0;

        // Hold reset low, then release it at a falling edge
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Single-sample streams: each is a partial frame of length one.
        // Most negative code gives the largest energy, 32768.
        push_sample(16'h8000, 1'b1, 1'b0);
        push_sample(16'h7FFF, 1'b1, 1'b0);
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'hFFFF, 1'b1, 1'b0);
        push_sample(16'h0001, 1'b1, 1'b0);

        // Short streams: full-scale swing, near silence, then a ramp
        push_sample(16'h8000, 1'b0, 1'b0);
        push_sample(16'h7FFF, 1'b0, 1'b0);
        push_sample(16'h8000, 1'b0, 1'b0);
        push_sample(16'h7FFF, 1'b1, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h0001, 1'b1, 1'b0);
        push_sample(16'h0010, 1'b0, 1'b0);
        push_sample(16'h0100, 1'b0, 1'b0);
        push_sample(16'h1000, 1'b0, 1'b0);
        push_sample(16'h4000, 1'b0, 1'b0);
        push_sample(16'hC000, 1'b1, 1'b0);

        // Two hop blocks: one closes mid-stream, the other on the last sample
        // with only one held, so a partial frame over both comes out
        run_stream(2 * HOP, 1'b1);

        // Pause the sender until every frame so far has come back
        hold_input();
        while (frames_due != 0) @(posedge aclk);

        // Random streams: mostly very short ones, some a little longer
        while (items_sent < MIN_ITEMS || streams_done < MIN_RUNS) begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(33, 96);
                default: len = $urandom_range(1, 32);
            endcase
            run_stream(len, $urandom_range(0, 2) != 0);
        end

        // Closing stretch with no idling on either side
        calm = 1'b1;
        repeat (8) run_stream($urandom_range(1, 40), 1'b0);
        hold_input();

        // Drain every expected frame, then give the back end time to show
        // anything extra
        while (frames_due != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
